[src/pwad_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths, reset values and fixed-point helpers for the pid block
// no dependencies; imported by every other file of the block

package pwad_pkg;

   // field and datapath widths
   localparam int GAIN_W    = 24;
   localparam int ERR_W     = 16;
   localparam int DRIVE_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int Q_FRAC    = 16;
   localparam int DIFF_W    = ERR_W + 2;
   localparam int PROD_W    = GAIN_W + 1 + DIFF_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int TRUNC_W   = ACC_W - Q_FRAC;
   localparam int DIV_DIGIT_BITS = 4;

   // default sizing
   localparam int HISTORY_LEN_DEF = 5;
   localparam int AXES_DEF        = 2;

   // register reset values, unsigned q8.16
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd65536;
   localparam logic [GAIN_W-1:0] AX0_INT_RST    = 24'd0;
   localparam logic [GAIN_W-1:0] AX0_DER_RST    = 24'd0;
   localparam logic [GAIN_W-1:0] AX1_INT_RST    = 24'd32768;
   localparam logic [GAIN_W-1:0] AX1_DER_RST    = 24'd59;
   localparam logic [GAIN_W-1:0] STEP_TIME_RST  = 24'd1842;
   localparam logic [GAIN_W-1:0] STEP_RATE_RST  = 24'd2332240;

   // saturation and drive limits
   localparam logic signed [TRUNC_W-1:0] SAT_HI   = TRUNC_W'(32767);
   localparam logic signed [TRUNC_W-1:0] SAT_LO   = -TRUNC_W'(32768);
   localparam logic signed [TRUNC_W-1:0] DRIVE_HI = TRUNC_W'(127);
   localparam logic signed [TRUNC_W-1:0] DRIVE_LO = -TRUNC_W'(128);
   localparam logic [DRIVE_W-1:0]        DRIVE_ZERO = 8'd128;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN = 3'd0,
      CSR_AX0_INT   = 3'd1,
      CSR_AX0_DER   = 3'd2,
      CSR_AX1_INT   = 3'd3,
      CSR_AX1_DER   = 3'd4,
      CSR_STEP_TIME = 3'd5,
      CSR_STEP_RATE = 3'd6
   } csr_idx_type;

   // memory access strobes from the sequencer to the axis store
   typedef struct packed {
      logic st_rd;
      logic st_wr;
      logic hist_rd;
      logic hist_wr;
   } mem_ctrl_type;

   // divider controls
   typedef struct packed {
      logic start;
      logic step;
   } div_ctrl_type;

   // divide by 65536 with truncation toward zero
   function automatic logic signed [TRUNC_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] x);
      logic signed [TRUNC_W-1:0] q;
      q = x[ACC_W-1:Q_FRAC];
      if (x[ACC_W-1] && (x[Q_FRAC-1:0] != '0)) begin
         q = q + TRUNC_W'(1);
      end
      return q;
   endfunction

   // clamp to 16 bit signed
   function automatic logic signed [ERR_W-1:0] sat16(input logic signed [TRUNC_W-1:0] v);
      logic signed [TRUNC_W-1:0] c;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end
      return c[ERR_W-1:0];
   endfunction

   // clamp to -128..127 and offset by 128
   function automatic logic [DRIVE_W-1:0] to_drive(input logic signed [TRUNC_W-1:0] v);
      logic signed [TRUNC_W-1:0] c;
      c = v;
      if (v > DRIVE_HI) begin
         c = DRIVE_HI;
      end else if (v < DRIVE_LO) begin
         c = DRIVE_LO;
      end
      return {~c[DRIVE_W-1], c[DRIVE_W-2:0]};
   endfunction

endpackage

[src/pwad_axis_store.sv]
`timescale 1ns / 1ps
// per-axis state memory and error history memory, registered reads
// depends on pwad_pkg

module pwad_axis_store import pwad_pkg::*; #(
   parameter int AXES        = AXES_DEF,
   parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mem_ctrl_type            ctrl,
   input  logic [AX_W-1:0]         st_addr,
   input  logic [ST_W-1:0]         st_wdata,
   output logic [ST_W-1:0]         st_rdata,
   input  logic [HA_W-1:0]         hist_addr,
   input  logic signed [ERR_W-1:0] hist_wdata,
   output logic signed [ERR_W-1:0] hist_rdata
);

   localparam int AX_W  = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int SUM_W = ERR_W + $clog2(HISTORY_LEN);
   localparam int PTR_W = $clog2(HISTORY_LEN);
   localparam int ST_W  = 2 * ERR_W + SUM_W + PTR_W + 1;
   localparam int HD    = AXES * HISTORY_LEN;
   localparam int HA_W  = $clog2(HD);

   logic [ST_W-1:0]  st_mem [AXES];
   logic [ERR_W-1:0] hist_mem [HD];

   logic [ST_W-1:0]  st_q_ff;
   logic             st_hit_ff;
   logic [ERR_W-1:0] hist_q_ff;
   logic [AXES-1:0]  valid_ff;

   // state memory: integrator, last error, history sum, pointer, full flag
   always_ff @(posedge clock) begin
      if (ctrl.st_wr) begin
         st_mem[st_addr] <= st_wdata;
      end
      if (ctrl.st_rd) begin
         st_q_ff <= st_mem[st_addr];
      end
   end

   // history memory, ring buffer per axis
   always_ff @(posedge clock) begin
      if (ctrl.hist_wr) begin
         hist_mem[hist_addr] <= hist_wdata;
      end
      if (ctrl.hist_rd) begin
         hist_q_ff <= hist_mem[hist_addr];
      end
   end

   // one valid bit per axis, an unwritten axis reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         st_hit_ff <= 1'b0;
      end else begin
         if (ctrl.st_wr) begin
            valid_ff[st_addr] <= 1'b1;
         end
         if (ctrl.st_rd) begin
            st_hit_ff <= valid_ff[st_addr];
         end
      end
   end

   assign st_rdata   = st_hit_ff ? st_q_ff : '0;
   assign hist_rdata = $signed(hist_q_ff);

endmodule

[src/pwad_avg_div.sv]
`timescale 1ns / 1ps
// history average: signed sum divided by the history length, truncated
// radix-16 restoring divider, one digit per cycle while step is asserted; depends on pwad_pkg

module pwad_avg_div import pwad_pkg::*; #(
   parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  div_ctrl_type            ctrl,
   input  logic signed [SUM_W-1:0] dividend,
   output logic signed [ERR_W:0]   avg,
   output logic                    done
);

   localparam int SUM_W     = ERR_W + $clog2(HISTORY_LEN);
   localparam int REM_W     = $clog2(HISTORY_LEN);
   localparam int DIV_STEPS = (SUM_W + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
   localparam int DIV_W     = DIV_STEPS * DIV_DIGIT_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(HISTORY_LEN);

   logic [DIV_W-1:0] work_ff;
   logic [REM_W-1:0] rem_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [SUM_W-1:0] mag;
   logic [DIV_W-1:0] work_in;
   logic [REM_W-1:0] rem_in;
   logic [ERR_W-1:0] quot;

   // magnitude of the sum, sign kept aside
   assign mag  = dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
   assign done = (cnt_ff == CNT_W'(DIV_STEPS));

   // one quotient digit: four compare and subtract steps
   always_comb begin
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] rem_v;
      logic [DIV_W-1:0] work_v;
      rem_v  = rem_ff;
      work_v = work_ff;
      trial  = '0;
      for (int i = 0; i < DIV_DIGIT_BITS; i++) begin
         trial  = {rem_v, work_v[DIV_W-1]};
         work_v = {work_v[DIV_W-2:0], 1'b0};
         if (trial >= DIVISOR) begin
            trial     = trial - DIVISOR;
            work_v[0] = 1'b1;
         end
         rem_v = trial[REM_W-1:0];
      end
      work_in = work_v;
      rem_in  = rem_v;
   end

   // load and step
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(DIV_STEPS);
      end else if (ctrl.start) begin
         work_ff <= DIV_W'(mag);
         rem_ff  <= '0;
         neg_ff  <= dividend[SUM_W-1];
         cnt_ff  <= '0;
      end else if (ctrl.step && !done) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
   end

   // quotient never exceeds 32768 in magnitude
   assign quot = work_ff[ERR_W-1:0];
   assign avg  = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

[src/pwad_mul.sv]
`timescale 1ns / 1ps
// shared multiplier: unsigned q8.16 gain times a signed operand, product registered
// depends on pwad_pkg

module pwad_mul import pwad_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [GAIN_W-1:0]        a,
   input  logic signed [DIFF_W-1:0] b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;

   // 25 x 18 signed product, one per cycle while en is high
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= $signed({1'b0, a}) * b;
      end
   end

   assign prod = prod_ff;

endmodule

[src/pid_with_averaged_derivative.sv]
`timescale 1ns / 1ps
// requests are handled one at a time: a new request is taken only once the result
// of the last one is out, and the pace is set by the single shared multiplier and the
// one-digit-per-cycle divider.
// an axis outside the configured range gives 128.
// reset (synchronous, active high) loads default gains and clears every axis' state;
// no clearing pass, per-axis valid bits make a fresh axis read as zero.

module pid_with_averaged_derivative import pwad_pkg::*; #(
   parameter int AXES        = AXES_DEF,
   parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ERR_W-1:0]     req_tdata,   // [15:0] loop_error
   input  logic                 req_tuser,   // [0] axis
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DRIVE_W-1:0]   rsp_tdata,   // [7:0] drive
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   localparam int AX_W  = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int SUM_W = ERR_W + $clog2(HISTORY_LEN);
   localparam int PTR_W = $clog2(HISTORY_LEN);
   localparam int ST_W  = 2 * ERR_W + SUM_W + PTR_W + 1;
   localparam int HD    = AXES * HISTORY_LEN;
   localparam int HA_W  = $clog2(HD);

   typedef enum logic [3:0] {
      S_IDLE, S_HREAD, S_INTEG, S_KI, S_KIACC, S_DIV, S_DMUL,
      S_DSAT, S_KD, S_KDACC, S_OUT, S_BYPASS
   } state_type;

   // registers
   state_type               state_ff, state_in;
   logic                    axis_ff, axis_in;
   logic [AX_W-1:0]         idx_ff, idx_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ERR_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0] last_ff, last_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic                    full_ff, full_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0] deriv_ff, deriv_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [GAIN_W-1:0]       prop_ff, ax0_int_ff, ax0_der_ff, ax1_int_ff, ax1_der_ff;
   logic [GAIN_W-1:0]       step_time_ff, step_rate_ff;

   // store and unit connections
   mem_ctrl_type            mem_ctrl;
   div_ctrl_type            div_ctrl;
   logic [AX_W-1:0]         st_addr;
   logic [ST_W-1:0]         st_wdata, st_rdata;
   logic [HA_W-1:0]         hist_addr;
   logic signed [ERR_W-1:0] hist_rdata;
   logic [PTR_W-1:0]        hist_ptr;
   logic signed [ERR_W:0]   avg;
   logic                    div_done;
   logic                    mul_en;
   logic [GAIN_W-1:0]       mul_a;
   logic signed [DIFF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;

   // datapath helpers
   logic                    req_accept, req_axis_ok, slot_free, wrap;
   logic [AX_W-1:0]         req_idx;
   logic signed [ERR_W-1:0] oldest;
   logic signed [SUM_W-1:0] new_sum;
   logic signed [ACC_W-1:0] prod_ext, integ_shift;
   logic signed [DIFF_W-1:0] err_ext, integ_ext, deriv_ext, diff;
   logic [GAIN_W-1:0]       ki, kd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_idx    = AX_W'(req_tuser);
   assign req_axis_ok = (int'(req_tuser) < AXES);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // gain selection: axis 0 own gains, any other axis the axis 1 gains
   assign ki = axis_ff ? ax1_int_ff : ax0_int_ff;
   assign kd = axis_ff ? ax1_der_ff : ax0_der_ff;

   // sign extensions
   assign prod_ext    = {prod[PROD_W-1], prod};
   assign integ_shift = {{(ACC_W - Q_FRAC - ERR_W){integ_ff[ERR_W-1]}}, integ_ff, {Q_FRAC{1'b0}}};
   assign err_ext     = {{(DIFF_W - ERR_W){err_ff[ERR_W-1]}}, err_ff};
   assign integ_ext   = {{(DIFF_W - ERR_W){integ_ff[ERR_W-1]}}, integ_ff};
   assign deriv_ext   = {{(DIFF_W - ERR_W){deriv_ff[ERR_W-1]}}, deriv_ff};
   assign diff        = err_ext - {avg[ERR_W], avg};

   // running history sum: drop the oldest entry once the ring is full
   assign oldest  = full_ff ? hist_rdata : '0;
   assign new_sum = sum_ff
                  - {{(SUM_W - ERR_W){oldest[ERR_W-1]}}, oldest}
                  + {{(SUM_W - ERR_W){last_ff[ERR_W-1]}}, last_ff};

   // ring pointer advance for the write-back
   assign wrap     = (ptr_ff == PTR_W'(HISTORY_LEN - 1));
   assign st_wdata = {full_ff | wrap, wrap ? '0 : ptr_ff + PTR_W'(1), sum_ff, err_ff, integ_ff};

   // history address: row of the axis, column of the pointer
   assign hist_ptr  = (state_ff == S_HREAD) ? st_rdata[2*ERR_W+SUM_W +: PTR_W] : ptr_ff;
   assign hist_addr = HA_W'(int'(idx_ff) * HISTORY_LEN + int'(hist_ptr));
   assign st_addr   = (state_ff == S_IDLE) ? req_idx : idx_ff;

   // sequencer next-state and datapath
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      idx_in       = idx_ff;
      err_in       = err_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      full_in      = full_ff;
      acc_in       = acc_ff;
      deriv_in     = deriv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_ctrl     = '0;
      div_ctrl     = '0;
      mul_en       = 1'b0;
      mul_a        = step_time_ff;
      mul_b        = err_ext;

      div_ctrl.step = (state_ff inside {S_KI, S_KIACC, S_DIV}) && !div_done;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               axis_in = req_tuser;
               idx_in  = req_idx;
               err_in  = $signed(req_tdata);
               if (req_axis_ok) begin
                  mem_ctrl.st_rd = 1'b1;
                  state_in       = S_HREAD;
               end else begin
                  state_in = S_BYPASS;
               end
            end
         end
         S_HREAD: begin
            // unpack axis state, fetch oldest history entry, start e * dt
            integ_in         = $signed(st_rdata[ERR_W-1:0]);
            last_in          = $signed(st_rdata[2*ERR_W-1:ERR_W]);
            sum_in           = $signed(st_rdata[2*ERR_W +: SUM_W]);
            ptr_in           = st_rdata[2*ERR_W+SUM_W +: PTR_W];
            full_in          = st_rdata[ST_W-1];
            mem_ctrl.hist_rd = 1'b1;
            mul_en           = 1'b1;
            state_in         = S_INTEG;
         end
         S_INTEG: begin
            // integrator update, history shift, average started, kp * e
            integ_in         = sat16(trunc_q16(integ_shift + prod_ext));
            sum_in           = new_sum;
            mem_ctrl.hist_wr = 1'b1;
            div_ctrl.start   = 1'b1;
            mul_en           = 1'b1;
            mul_a            = prop_ff;
            state_in         = S_KI;
         end
         S_KI: begin
            acc_in   = prod_ext;
            mul_en   = 1'b1;
            mul_a    = ki;
            mul_b    = integ_ext;
            state_in = S_KIACC;
         end
         S_KIACC: begin
            acc_in   = acc_ff + prod_ext;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            // (e - avg) / dt
            mul_en   = 1'b1;
            mul_a    = step_rate_ff;
            mul_b    = diff;
            state_in = S_DSAT;
         end
         S_DSAT: begin
            deriv_in = sat16(trunc_q16(prod_ext));
            state_in = S_KD;
         end
         S_KD: begin
            mul_en   = 1'b1;
            mul_a    = kd;
            mul_b    = deriv_ext;
            state_in = S_KDACC;
         end
         S_KDACC: begin
            acc_in   = acc_ff + prod_ext;
            state_in = S_OUT;
         end
         S_OUT: begin
            // result out and axis state written back together
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = to_drive(trunc_q16(acc_ff));
               mem_ctrl.st_wr = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_BYPASS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DRIVE_ZERO;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, registered outputs, datapath and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prop_ff      <= PROP_GAIN_RST;
         ax0_int_ff   <= AX0_INT_RST;
         ax0_der_ff   <= AX0_DER_RST;
         ax1_int_ff   <= AX1_INT_RST;
         ax1_der_ff   <= AX1_DER_RST;
         step_time_ff <= STEP_TIME_RST;
         step_rate_ff <= STEP_RATE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         axis_ff      <= axis_in;
         idx_ff       <= idx_in;
         err_ff       <= err_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         full_ff      <= full_in;
         acc_ff       <= acc_in;
         deriv_ff     <= deriv_in;
         if (csr_valid) begin
            case (csr_idx_type'(csr_index))
               CSR_PROP_GAIN: prop_ff      <= csr_wdata;
               CSR_AX0_INT:   ax0_int_ff   <= csr_wdata;
               CSR_AX0_DER:   ax0_der_ff   <= csr_wdata;
               CSR_AX1_INT:   ax1_int_ff   <= csr_wdata;
               CSR_AX1_DER:   ax1_der_ff   <= csr_wdata;
               CSR_STEP_TIME: step_time_ff <= csr_wdata;
               CSR_STEP_RATE: step_rate_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   pwad_axis_store #(
      .AXES        (AXES),
      .HISTORY_LEN (HISTORY_LEN)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mem_ctrl),
      .st_addr    (st_addr),
      .st_wdata   (st_wdata),
      .st_rdata   (st_rdata),
      .hist_addr  (hist_addr),
      .hist_wdata (last_ff),
      .hist_rdata (hist_rdata)
   );

   pwad_avg_div #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (new_sum),
      .avg      (avg),
      .done     (div_done)
   );

   pwad_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

endmodule

[src/pwad_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the pid block over time, bound to the top level
// depends on pwad_pkg and pid_with_averaged_derivative

module pwad_checker import pwad_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [ERR_W-1:0]     req_tdata,
   input logic                 req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DRIVE_W-1:0]   rsp_tdata,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [GAIN_W-1:0]    csr_wdata
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // one request at a time: ready drops once a request is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // no result can appear in the cycle right after a request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

endmodule

bind pid_with_averaged_derivative pwad_checker u_pwad_checker (.*);

[tb/pid_drive_checker.sv]
`timescale 1ns / 1ps
// drive checker for the pid block: mirrors the gain registers and axis state,
// predicts each drive value and compares it with the response stream
// depends on pwad_pkg for widths, register indexes and reset gains

module pid_drive_checker import pwad_pkg::*; #(
   parameter int HLEN = HISTORY_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [ERR_W-1:0]     req_tdata,   // [15:0] loop_error
   input  logic                 req_tuser,   // [0] axis
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [DRIVE_W-1:0]   rsp_tdata,   // [7:0] drive
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count,
   output int                   request_count,
   output int                   result_count,
   output int                   write_count
);

   // mirrored gain registers
   logic [GAIN_W-1:0] kp, ki_ax0, kd_ax0, ki_ax1, kd_ax1, dt_q, rate_q;

   // mirrored per-axis state
   logic signed [ERR_W-1:0] integ_q [2];
   logic signed [ERR_W-1:0] prev_err [2];
   logic signed [ERR_W-1:0] err_hist [2][HLEN];

   logic [DRIVE_W-1:0] pending_drives [$];

   initial begin
      mismatch_count = 0;
      request_count  = 0;
      result_count   = 0;
      write_count    = 0;
   end

   assign pending_count = pending_drives.size();

   function automatic logic signed [ERR_W-1:0] clamp16(input longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // one controller step on the mirrored state, returns the drive byte
   function automatic logic [DRIVE_W-1:0] predict_drive(input logic ax,
                                                        input logic signed [ERR_W-1:0] err);
      longint e, ki, kd, acc, avg, deriv, total;
      e  = longint'(err);
      ki = ax ? longint'(ki_ax1) : longint'(ki_ax0);
      kd = ax ? longint'(kd_ax1) : longint'(kd_ax0);

      // integrator, truncated toward zero then saturated
      acc = longint'(integ_q[ax]) * 65536 + e * longint'(dt_q);
      integ_q[ax] = clamp16(acc / 65536);

      // shift previous error into the history and average it
      for (int i = HLEN - 1; i > 0; i--) begin
         err_hist[ax][i] = err_hist[ax][i-1];
      end
      err_hist[ax][0] = prev_err[ax];
      acc = 0;
      for (int i = 0; i < HLEN; i++) begin
         acc += longint'(err_hist[ax][i]);
      end
      avg = acc / HLEN;

      deriv = longint'(clamp16(((e - avg) * longint'(rate_q)) / 65536));
      total = (longint'(kp) * e + ki * longint'(integ_q[ax]) + kd * deriv) / 65536;
      if (total > 127) begin
         total = 127;
      end else if (total < -128) begin
         total = -128;
      end
      prev_err[ax] = err;
      return 8'(total + 128);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp     = PROP_GAIN_RST;
         ki_ax0 = AX0_INT_RST;
         kd_ax0 = AX0_DER_RST;
         ki_ax1 = AX1_INT_RST;
         kd_ax1 = AX1_DER_RST;
         dt_q   = STEP_TIME_RST;
         rate_q = STEP_RATE_RST;
         for (int a = 0; a < 2; a++) begin
            integ_q[a]  = '0;
            prev_err[a] = '0;
            for (int i = 0; i < HLEN; i++) begin
               err_hist[a][i] = '0;
            end
         end
         pending_drives.delete();
      end else begin
         // register writes, unknown indexes change nothing
         if (csr_valid && csr_ready) begin
            write_count++;
            case (csr_index)
               CSR_PROP_GAIN: kp     = csr_wdata;
               CSR_AX0_INT:   ki_ax0 = csr_wdata;
               CSR_AX0_DER:   kd_ax0 = csr_wdata;
               CSR_AX1_INT:   ki_ax1 = csr_wdata;
               CSR_AX1_DER:   kd_ax1 = csr_wdata;
               CSR_STEP_TIME: dt_q   = csr_wdata;
               CSR_STEP_RATE: rate_q = csr_wdata;
               default: ;
            endcase
         end

         // compare each accepted drive with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (pending_drives.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: drive %0d arrived with no request outstanding",
                           $time, rsp_tdata);
               end
               mismatch_count++;
            end else begin
               logic [DRIVE_W-1:0] want;
               want = pending_drives.pop_front();
               if (rsp_tdata !== want) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: drive mismatch, expected %0d got %0d",
                              $time, want, rsp_tdata);
                  end
                  mismatch_count++;
               end
            end
         end

         // predict on every accepted request
         if (req_tvalid && req_tready) begin
            request_count++;
            pending_drives.push_back(predict_drive(req_tuser, req_tdata));
         end
      end
   end

endmodule

[tb/pid_with_averaged_derivative_test.sv]
`timescale 1ns / 1ps
// top of the pid testbench: clock, reset, request and register stimulus, verdict
// depends on pwad_pkg, pid_with_averaged_derivative and pid_drive_checker

module pid_with_averaged_derivative_test;
   import pwad_pkg::*;

   typedef enum int {
      GAINS_RESET, GAINS_ZERO, GAINS_FULL, GAINS_GENTLE,
      GAINS_INTEGRAL, GAINS_DERIV, GAINS_RANDOM
   } gain_profile_e;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;
   localparam int PHASES     = 8;
   localparam int PHASE_REQS = 212;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [ERR_W-1:0]     req_tdata;   // [15:0] loop_error
   logic                 req_tuser;   // [0] axis
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DRIVE_W-1:0]   rsp_tdata;   // [7:0] drive
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wdata;

   int mismatch_count, pending_count, request_count, result_count, write_count;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   pid_with_averaged_derivative uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   pid_drive_checker checker_i (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .mismatch_count, .pending_count, .request_count, .result_count, .write_count
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   // run limit, several times the slowest correct run
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // all tasks start and end just after a falling edge
   task automatic send_request(input logic ax, input logic [ERR_W-1:0] err);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = ax;
      req_tdata  = err;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // pick a gain set, write every register plus one unmapped index
   task automatic apply_profile(input gain_profile_e prof);
      logic [GAIN_W-1:0] kp, ki0, kd0, ki1, kd1, dt, rate;
      kp = PROP_GAIN_RST; ki0 = AX0_INT_RST; kd0 = AX0_DER_RST;
      ki1 = AX1_INT_RST; kd1 = AX1_DER_RST; dt = STEP_TIME_RST; rate = STEP_RATE_RST;
      case (prof)
         GAINS_ZERO: begin
            kp = '0; ki0 = '0; kd0 = '0; ki1 = '0; kd1 = '0; dt = '0; rate = '0;
         end
         GAINS_FULL: begin
            kp = '1; ki0 = '1; kd0 = '1; ki1 = '1; kd1 = '1; dt = '1; rate = '1;
         end
         GAINS_GENTLE: begin
            kp   = $urandom_range(4096);
            ki0  = $urandom_range(8192);
            ki1  = $urandom_range(8192);
            kd0  = $urandom_range(512);
            kd1  = $urandom_range(512);
            dt   = $urandom_range(65536);
            rate = $urandom_range(262144);
         end
         GAINS_INTEGRAL: begin
            kp = '0; kd0 = '0; kd1 = '0;
            ki0  = $urandom_range(256, 1);
            ki1  = $urandom_range(256, 1);
            dt   = $urandom_range(196608, 16384);
            rate = $urandom_range(262144);
         end
         GAINS_DERIV: begin
            kp = '0; ki0 = '0; ki1 = '0;
            kd0  = $urandom_range(256, 1);
            kd1  = $urandom_range(256, 1);
            dt   = $urandom_range(65536);
            rate = $urandom_range(24'hffffff, 65536);
         end
         GAINS_RANDOM: begin
            kp  = 24'($urandom); ki0 = 24'($urandom); kd0  = 24'($urandom);
            ki1 = 24'($urandom); kd1 = 24'($urandom); dt   = 24'($urandom);
            rate = 24'($urandom);
         end
         default: ;
      endcase
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_AX0_INT, ki0);
      write_reg(CSR_AX0_DER, kd0);
      write_reg(CSR_AX1_INT, ki1);
      write_reg(CSR_AX1_DER, kd1);
      write_reg(CSR_STEP_TIME, dt);
      write_reg(CSR_NO_REG, 24'($urandom));
      write_reg(CSR_STEP_RATE, rate);
   endtask

   // mix of full-range, small, mid-size and extreme errors
   function automatic logic [ERR_W-1:0] pick_error();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'(int'($urandom_range(128)) - 64);
         2: return 16'(int'($urandom_range(4096)) - 2048);
         default: begin
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
      endcase
   endfunction

   initial begin
      gain_profile_e sched [PHASES];
      sched = '{GAINS_GENTLE, GAINS_RESET, GAINS_FULL, GAINS_INTEGRAL,
                GAINS_DERIV, GAINS_ZERO, GAINS_RANDOM, GAINS_GENTLE};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_PROP_GAIN;
      csr_wdata  = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes on both axes under reset gains,
      // derivative saturating on large steps
      send_request(1'b0, 16'h0000);
      send_request(1'b0, 16'h7fff);
      send_request(1'b0, 16'h8000);
      send_request(1'b0, 16'h7fff);
      send_request(1'b0, 16'hffff);
      send_request(1'b0, 16'h0001);
      send_request(1'b1, 16'h7fff);
      send_request(1'b1, 16'h8000);
      send_request(1'b1, 16'h0000);
      send_request(1'b1, 16'd100);
      send_request(1'b1, -16'sd100);
      send_request(1'b1, 16'd12);
      wait_drained();

      // directed: huge step time drives both integrators into saturation
      write_reg(CSR_STEP_TIME, 24'hffffff);
      write_reg(CSR_AX0_INT, 24'd256);
      for (int i = 0; i < 2; i++) begin
         send_request(1'b0, 16'h7fff);
         send_request(1'b1, 16'h7fff);
      end
      for (int i = 0; i < 3; i++) begin
         send_request(1'b0, 16'h8000);
         send_request(1'b1, 16'h8000);
      end
      wait_drained();

      // random phases, each with its own gains and idling pattern
      for (int ph = 0; ph < PHASES; ph++) begin
         apply_profile(sched[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         for (int n = 0; n < PHASE_REQS; n++) begin
            send_request(1'($urandom), pick_error());
         end
         wait_drained();
      end

      // let any stray response show up
      repeat (30) @(negedge clock);

      $display("sent %0d loop errors on both axes through %0d gain settings and four idling mixes",
               request_count, PHASES + 2);
      $display("compared %0d drive values after %0d register writes, %0d mismatches",
               result_count, write_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
